// File: rtl/bwm_pkg.sv
`default_nettype none
package bwm_pkg;

  // Pixels in one mask byte, and one lane more for the end-of-row close
  localparam int PIX = 8;
  localparam int LANES = PIX + 1;
  localparam int OUT_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LEFT     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_RIGHT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_TOP      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MASK_ORIGIN_X = 2'd3;

  localparam logic [PIX-1:0] FULL_BYTE = 8'hFF;

  // Everything the lanes found for one byte
  typedef struct packed {
    logic [LANES-1:0]                close;
    logic [LANES-1:0][OUT_BITS-1:0]  x;
    logic [LANES-1:0][OUT_BITS-1:0]  w;
    logic [OUT_BITS-1:0]             y;
  } entry_t;

endpackage
`default_nettype wire

// File: rtl/bwm_if.sv
`default_nettype none
interface bwm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] mask_byte;
  logic       row_start;
  logic       row_end;

  modport source (output valid, mask_byte, row_start, row_end, input ready);
  modport sink (input valid, mask_byte, row_start, row_end, output ready);
endinterface

interface bwm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] span_x;
  logic signed [15:0] span_y;
  logic        [15:0] span_width;
  logic               last;

  modport source (output valid, span_x, span_y, span_width, last, input ready);
  modport sink (input valid, span_x, span_y, span_width, last, output ready);
endinterface
`default_nettype wire

// File: rtl/bwm_lane.sv
`default_nettype none
module bwm_lane #(
  parameter int COORD_BITS = 16,
  parameter int LANE = 0
) (
  input  logic [bwm_pkg::PIX-1:0] pix,
  input  logic                    open_in,
  input  logic [COORD_BITS-1:0]   px,
  input  logic [COORD_BITS-1:0]   carried,
  output logic                    close,
  output logic [COORD_BITS-1:0]   span_x,
  output logic [COORD_BITS-1:0]   span_w
);
  import bwm_pkg::*;

  localparam int IDX = (LANE < PIX) ? LANE : PIX - 1;
  localparam int PREV = (LANE > 0) ? LANE - 1 : 0;

  logic [PIX-1:0] starts;
  logic           prev;
  logic           found;
  logic [2:0]     jj;
  logic [3:0]     span_len;

  // Flag the pixels where a run begins
  always_comb begin
    starts[0] = pix[0] && !open_in;
    for (int i = 1; i < PIX; i++) begin
      starts[i] = pix[i] && !pix[i-1];
    end
  end

  // Close where an uncovered pixel follows a covered one; the last lane closes at row end
  always_comb begin
    if (LANE == 0) begin
      prev = open_in;
    end else begin
      prev = pix[PREV];
    end
    if (LANE < PIX) begin
      close = prev && !pix[IDX];
    end else begin
      close = prev;
    end
  end

  // Find the nearest run start to the left of this lane
  always_comb begin
    found = 1'b0;
    jj = '0;
    for (int j = 0; j < PIX; j++) begin
      if (j < LANE && starts[j]) begin
        found = 1'b1;
        jj = 3'(j);
      end
    end
  end

  assign span_len = 4'(LANE) - {1'b0, jj};

  // Span start and width: local start, or the run carried in from earlier bytes
  always_comb begin
    if (found) begin
      span_x = px + COORD_BITS'(jj);
      span_w = COORD_BITS'(span_len);
    end else begin
      span_x = carried;
      span_w = px + COORD_BITS'(LANE) - carried;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bwm_merge.sv
`default_nettype none
module bwm_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            a_valid,
  input  bwm_pkg::entry_t a_entry,
  output logic            take,
  bwm_out_if.source       out_ch
);
  import bwm_pkg::*;

  logic [LANES-1:0] mask_r, mask_nxt;
  entry_t           entry_r;
  logic [3:0]       sel;
  logic [LANES-1:0] rem;
  logic             fire;

  // Pick the leftmost pending close
  always_comb begin
    sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = 4'(i);
      end
    end
    rem = mask_r;
    rem[sel] = 1'b0;
  end

  assign out_ch.valid      = |mask_r;
  assign out_ch.span_x     = entry_r.x[sel];
  assign out_ch.span_y     = entry_r.y;
  assign out_ch.span_width = entry_r.w[sel];
  assign out_ch.last       = ~|rem;

  assign fire = out_ch.valid && out_ch.ready;
  assign take = ~|mask_r || (fire && ~|rem);

  // Load a new byte when done, otherwise drop the beat just sent
  always_comb begin
    mask_nxt = mask_r;
    if (take) begin
      mask_nxt = a_valid ? a_entry.close : '0;
    end else if (fire) begin
      mask_nxt = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && a_valid) begin
      entry_r <= a_entry;
    end
  end

endmodule
`default_nettype wire

// File: rtl/bw_mask_row_to_spans_core.sv
// A byte waits in the holding register, then the merge stage offers its first span.
// Throughput: one byte per cycle while each byte closes at most one span and out_ch is
// ready; otherwise one span per ready cycle from the single merge output (up to five).
// One byte can be accepted while the merge stage still holds spans of the previous one.
// Reset: synchronous, active low; clears run state, row counters and config registers.
`default_nettype none
module bw_mask_row_to_spans_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bwm_in_if.sink                             in_ch,
  bwm_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [bwm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bwm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import bwm_pkg::*;

  logic signed [15:0]     clip_left_r, clip_right_r, mask_origin_x_r;
  logic                   run_open_r, run_open_nxt;
  logic [COORD_BITS-1:0]  run_begin_r, run_begin_nxt;
  logic [COORD_BITS-1:0]  pixel_x_r, pixel_x_nxt;
  logic [COORD_BITS-1:0]  row_y_r, row_y_nxt;
  logic                   a_valid_r, a_valid_nxt;
  entry_t                 a_entry_r, a_entry_nxt;

  logic                   acc, take;
  logic [2:0]             le, re_rem;
  logic signed [16:0]     start17;
  logic signed [31:0]     start32;
  logic signed [31:0]     top32;
  logic [COORD_BITS-1:0]  start_c;
  logic [PIX-1:0]         bm;
  logic [PIX-1:0]         pix;
  logic [COORD_BITS-1:0]  px_eff;
  logic                   open_eff;
  logic [LANES-1:0]       close;
  logic [COORD_BITS-1:0]  lane_x [LANES];
  logic [COORD_BITS-1:0]  lane_w [LANES];

  function automatic logic [OUT_BITS-1:0] to_out(input logic [COORD_BITS-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[OUT_BITS-1:0];
  endfunction

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !a_valid_r || take;

  // Row start position aligned down to the mask byte grid
  assign le      = clip_left_r[2:0] - mask_origin_x_r[2:0];
  assign re_rem  = clip_right_r[2:0] - mask_origin_x_r[2:0];
  assign start17 = {clip_left_r[15], clip_left_r} - 17'(le);
  assign start32 = 32'(start17);
  assign start_c = COORD_BITS'(start32);
  assign top32   = 32'(signed'(cfg_data));

  // Apply the clip masks to the first and last byte of a row
  always_comb begin
    bm = in_ch.mask_byte;
    if (in_ch.row_start) begin
      bm = bm & (FULL_BYTE >> le);
    end
    if (in_ch.row_end && re_rem != 3'd0) begin
      bm = bm & ~(FULL_BYTE >> re_rem);
    end
    for (int i = 0; i < PIX; i++) begin
      pix[i] = bm[PIX-1-i];
    end
  end

  assign px_eff   = in_ch.row_start ? start_c : pixel_x_r;
  assign open_eff = in_ch.row_start ? 1'b0 : run_open_r;

  // One lane per pixel, plus one for the end-of-row close
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic lane_close;
    bwm_lane #(.COORD_BITS(COORD_BITS), .LANE(k)) u_lane (
      .pix     (pix),
      .open_in (open_eff),
      .px      (px_eff),
      .carried (run_begin_r),
      .close   (lane_close),
      .span_x  (lane_x[k]),
      .span_w  (lane_w[k])
    );
    if (k < PIX) begin : g_mid
      assign close[k] = lane_close;
    end else begin : g_end
      assign close[k] = lane_close && in_ch.row_end;
    end
  end

  // Gather lane results into the holding stage
  always_comb begin
    a_entry_nxt.close = close;
    a_entry_nxt.y = to_out(row_y_r);
    for (int i = 0; i < LANES; i++) begin
      a_entry_nxt.x[i] = to_out(lane_x[i]);
      a_entry_nxt.w[i] = to_out(lane_w[i]);
    end
  end

  // Advance run and row state for the accepted byte; a clip_top write takes priority
  always_comb begin
    run_open_nxt  = run_open_r;
    run_begin_nxt = run_begin_r;
    pixel_x_nxt   = pixel_x_r;
    row_y_nxt     = row_y_r;
    if (cfg_we && cfg_index == CFG_CLIP_TOP) begin
      row_y_nxt = COORD_BITS'(top32);
    end else if (acc) begin
      run_open_nxt  = pix[PIX-1] && !in_ch.row_end;
      run_begin_nxt = lane_x[LANES-1];
      pixel_x_nxt   = px_eff + COORD_BITS'(PIX);
      if (in_ch.row_end) begin
        row_y_nxt = row_y_r + COORD_BITS'(1);
      end
    end
  end

  assign a_valid_nxt = acc || (a_valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r  <= 1'b0;
      run_begin_r <= '0;
      pixel_x_r   <= '0;
      row_y_r     <= '0;
      a_valid_r   <= 1'b0;
    end else begin
      run_open_r  <= run_open_nxt;
      run_begin_r <= run_begin_nxt;
      pixel_x_r   <= pixel_x_nxt;
      row_y_r     <= row_y_nxt;
      a_valid_r   <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_entry_r <= a_entry_nxt;
    end
  end

  // Hold configuration registers; clip_top only loads the row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r     <= '0;
      clip_right_r    <= '0;
      mask_origin_x_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_LEFT:     clip_left_r     <= cfg_data;
        CFG_CLIP_RIGHT:    clip_right_r    <= cfg_data;
        CFG_CLIP_TOP: begin
        end
        CFG_MASK_ORIGIN_X: mask_origin_x_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Serialize the spans of each byte
  bwm_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .a_valid (a_valid_r),
    .a_entry (a_entry_r),
    .take    (take),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// File: tb/bw_mask_row_to_spans_core_test.sv
`default_nettype none
module bw_mask_row_to_spans_core_test;
  import bwm_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 200;
  localparam int LONG_ROW_BYTES = 40;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_BEATS    = 66;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic        last;
  } span_t;

  // One directed beat; typed rows carry the span read straight off the spec
  typedef struct packed {
    logic [7:0]  mask_byte;
    logic        row_start;
    logic        row_end;
    logic        typed;
    logic        has_span;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
  } step_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  bwm_in_if  in_if();
  bwm_out_if out_if();

  bw_mask_row_to_spans_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the clip settings and the run tracker
  logic [15:0] c_left, c_right, c_origin;
  logic        p_active;
  logic [15:0] p_run_x, p_cursor, p_line_y;

  span_t byte_spans[$];
  span_t pending_spans[$];

  bit gaps_on;
  bit stalls_on;
  bit hold_request;
  int mismatch_count;
  int spans_checked;
  int beats_sent;
  int settings_used;
  int densest_byte;
  int cycle_count;

  step_row_t directed_rows [0:15] = '{
    '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 16'd8},
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, 16'd2, 16'd1},
    '{8'h01, 1'b1, 1'b1, 1'b1, 1'b1, 16'd7, 16'd3, 16'd1},
    '{8'hAA, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'h55, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'h01, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'h55, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0, 16'd7, 16'd32},
    '{8'h01, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
    '{8'h80, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, 16'd8, 16'd1},
    '{8'hC0, 1'b0, 1'b0, 1'b1, 1'b1, 16'd8, 16'd9, 16'd2},
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0}
  };

  // Clip settings for the edge cases: left, right, top, origin
  logic [15:0] clip_sets [0:2][0:3] = '{
    '{16'd3,    16'd13,   16'hFFFB, 16'd0},
    '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8001},
    '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bw_mask_row_to_spans_core: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    $display("span %0d: %s got %04h want %04h", spans_checked, what, got, want);
  endtask

  function automatic span_t close_run();
    span_t s;
    s.x = p_run_x;
    s.y = p_line_y;
    s.w = p_cursor - p_run_x;
    s.last = 1'b0;
    return s;
  endfunction

  // Clip one mask byte, walk its pixels and collect the spans it closes
  function automatic void trace_mask_byte(input logic [7:0] mbyte, input logic rs,
                                          input logic re);
    logic [7:0] bits;
    logic [15:0] diff;
    logic [2:0] lead;
    logic [2:0] tail;
    bits = mbyte;
    byte_spans.delete();
    if (rs) begin
      diff = c_left - c_origin;
      lead = diff[2:0];
      p_active = 1'b0;
      p_cursor = c_left - {13'd0, lead};
      bits = bits & (FULL_BYTE >> lead);
    end
    if (re) begin
      diff = c_right - c_origin;
      tail = diff[2:0];
      // a zero remainder keeps the whole byte
      if (tail != 3'd0) bits = bits & (FULL_BYTE << (4'd8 - {1'b0, tail}));
    end
    for (int i = PIX - 1; i >= 0; i--) begin
      if (bits[i]) begin
        if (!p_active) begin
          p_run_x = p_cursor;
          p_active = 1'b1;
        end
      end else if (p_active) begin
        byte_spans.push_back(close_run());
        p_active = 1'b0;
      end
      p_cursor = p_cursor + 16'd1;
    end
    if (re) begin
      if (p_active) begin
        byte_spans.push_back(close_run());
        p_active = 1'b0;
      end
      p_line_y = p_line_y + 16'd1;
    end
    if (byte_spans.size() > 0) byte_spans[byte_spans.size() - 1].last = 1'b1;
  endfunction

  // Offer one beat, with an optional idle burst ahead of it, and wait for it to go in
  task automatic offer_beat(input logic [7:0] mbyte, input logic rs, input logic re);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.mask_byte <= mbyte;
    in_if.row_start <= rs;
    in_if.row_end   <= re;
    do @(posedge clk); while (!in_if.ready);
    beats_sent++;
  endtask

  task automatic send_and_predict(input logic [7:0] mbyte, input logic rs, input logic re);
    offer_beat(mbyte, rs, re);
    trace_mask_byte(mbyte, rs, re);
    if (byte_spans.size() > densest_byte) densest_byte = byte_spans.size();
    foreach (byte_spans[i]) pending_spans.push_back(byte_spans[i]);
  endtask

  // Drop valid, wait for every span, then give zero-span bytes time to retire
  task automatic drain_and_settle();
    in_if.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four configuration registers back to back; row_y follows clip_top
  task automatic write_settings(input logic [15:0] l, input logic [15:0] r,
                                input logic [15:0] t, input logic [15:0] o);
    c_left   = l;
    c_right  = r;
    c_origin = o;
    p_line_y = t;
    settings_used++;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CLIP_LEFT;
    cfg_data  <= l;
    @(posedge clk);
    cfg_index <= CFG_CLIP_RIGHT;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= CFG_CLIP_TOP;
    cfg_data  <= t;
    @(posedge clk);
    cfg_index <= CFG_MASK_ORIGIN_X;
    cfg_data  <= o;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_mask_byte();
    case ($urandom_range(0, 7))
      0: return 8'hFF;
      1: return 8'h00;
      2: return 8'h55;
      3: return 8'hAA;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Span sink: check each accepted beat, then pick the next ready
  initial begin : span_sink
    int hold_left;
    span_t want;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_spans.size() == 0) begin
          report_mismatch("span with none pending, x", out_if.span_x, 16'd0);
        end else begin
          want = pending_spans.pop_front();
          if (out_if.span_x !== want.x) report_mismatch("span_x", out_if.span_x, want.x);
          if (out_if.span_y !== want.y) report_mismatch("span_y", out_if.span_y, want.y);
          if (out_if.span_width !== want.w)
            report_mismatch("span_width", out_if.span_width, want.w);
          if (out_if.last !== want.last)
            report_mismatch("last", {15'd0, out_if.last}, {15'd0, want.last});
        end
        spans_checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_request) begin
        // long hold-off so the block fills and stalls its input
        hold_request = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_if.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 11);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int len;
    int sent;
    span_t typed_span;
    in_if.valid     <= 1'b0;
    in_if.mask_byte <= 8'h00;
    in_if.row_start <= 1'b0;
    in_if.row_end   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_CLIP_LEFT;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    c_left = '0;
    c_right = '0;
    c_origin = '0;
    p_active = 1'b0;
    p_run_x = '0;
    p_cursor = '0;
    p_line_y = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_request = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset settings
    foreach (directed_rows[i]) begin
      offer_beat(directed_rows[i].mask_byte, directed_rows[i].row_start,
                 directed_rows[i].row_end);
      trace_mask_byte(directed_rows[i].mask_byte, directed_rows[i].row_start,
                      directed_rows[i].row_end);
      if (byte_spans.size() > densest_byte) densest_byte = byte_spans.size();
      if (directed_rows[i].typed) begin
        if (directed_rows[i].has_span) begin
          typed_span.x = directed_rows[i].x;
          typed_span.y = directed_rows[i].y;
          typed_span.w = directed_rows[i].w;
          typed_span.last = 1'b1;
          pending_spans.push_back(typed_span);
        end
      end else begin
        foreach (byte_spans[k]) pending_spans.push_back(byte_spans[k]);
      end
    end
    drain_and_settle();

    // Clip edges off the byte grid and at the coordinate extremes
    foreach (clip_sets[s]) begin
      write_settings(clip_sets[s][0], clip_sets[s][1], clip_sets[s][2], clip_sets[s][3]);
      send_and_predict(8'hFF, 1'b1, 1'b1);
      send_and_predict(8'hFF, 1'b1, 1'b0);
      send_and_predict(8'hFF, 1'b0, 1'b1);
      drain_and_settle();
    end

    // One long run that starts just below the coordinate wrap and crosses it
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    write_settings(16'hFFF0, 16'd0, 16'd256, 16'd0);
    for (int k = 0; k < LONG_ROW_BYTES; k++)
      send_and_predict(8'hFF, k == 0, k == LONG_ROW_BYTES - 1);
    drain_and_settle();

    // Random rows, mostly well formed, under fresh settings per phase
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_settings(pick_coord(), pick_coord(), pick_coord(), pick_coord());
      gaps_on = (ph != RANDOM_PHASES - 1);
      stalls_on = (ph != RANDOM_PHASES - 1);
      if (ph == 1) hold_request = 1'b1;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(0, 4) != 0) begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            send_and_predict(pick_mask_byte(), k == 0, k == len - 1);
            sent++;
          end
        end else begin
          send_and_predict(pick_mask_byte(), 1'($urandom), 1'($urandom));
          sent++;
        end
      end
      drain_and_settle();
    end

    repeat (16) @(posedge clk);
    $display("run: %0d mask bytes under %0d clip settings, %0d spans compared",
             beats_sent, settings_used, spans_checked);
    $display("run: densest byte closed %0d spans, one %0d-cycle output hold",
             densest_byte, LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("bw_mask_row_to_spans_core: match");
    end else begin
      $display("bw_mask_row_to_spans_core: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/bwm_pkg.sv
rtl/bwm_if.sv
rtl/bwm_lane.sv
rtl/bwm_merge.sv
rtl/bw_mask_row_to_spans_core.sv
tb/bw_mask_row_to_spans_core_test.sv
